// File: sv/rpn_calculator_stack_core_macros.svh
// Assertion macros shared by the RPN stack calculator RTL.
// Used by files that include it; expects clk_i and rst_ni in scope.
`ifndef RPN_CALCULATOR_STACK_CORE_MACROS_SVH
`define RPN_CALCULATOR_STACK_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define RPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define RPN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RPN_ASSERT(lbl, prop, msg)
`define RPN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: sv/rpn_pkg.sv
// Shared types, codes and sizes of the RPN stack calculator.
// No dependencies; imported by every module of the block.
package rpn_pkg;

  localparam int VALUE_W     = 32;
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int STEP_W      = $clog2(VALUE_W);

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_DIGIT = 3'd2,
    CMD_OPER  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_UNDERFLOW = 2'd1,
    STS_DIV_ZERO  = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] push_value;
    logic [3:0]         digit;
    logic [1:0]         op_code;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] popped_value;
    logic [4:0]         depth;
    logic               is_empty;
    logic [1:0]         status;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic rd_en;
    logic div_start;
    logic commit;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_go;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: sv/rpn_div.sv
// Bit-serial signed truncating divider, one quotient bit per cycle.
// Depends on rpn_pkg and the assertion macro header.
`include "rpn_calculator_stack_core_macros.svh"

module rpn_div import rpn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VALUE_W-1:0] dividend_i,
  input  logic [VALUE_W-1:0] divisor_i,
  output logic               done_o,
  output logic [VALUE_W-1:0] quotient_o
);

  logic               busy_q, done_q, neg_q;
  logic [STEP_W-1:0]  step_q;
  logic [VALUE_W-1:0] rem_q;
  logic [VALUE_W-1:0] quo_q, dvs_q;
  logic [VALUE_W-1:0] a_mag, b_mag;
  logic [VALUE_W:0]   rem_sh, diff;
  logic               last_step;

  // Operand magnitudes and one restoring step.
  assign a_mag     = dividend_i[VALUE_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign b_mag     = divisor_i[VALUE_W-1] ? (~divisor_i + 1'b1) : divisor_i;
  assign rem_sh    = {rem_q, quo_q[VALUE_W-1]};
  assign diff      = rem_sh - {1'b0, dvs_q};
  assign last_step = (step_q == STEP_W'(VALUE_W - 1));

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift registers. The remainder stays below the
  // divisor magnitude, so it always fits in VALUE_W bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= a_mag;
      dvs_q <= b_mag;
      neg_q <= dividend_i[VALUE_W-1] ^ divisor_i[VALUE_W-1];
    end else if (busy_q) begin
      if (!diff[VALUE_W]) begin
        rem_q <= diff[VALUE_W-1:0];
        quo_q <= {quo_q[VALUE_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[VALUE_W-1:0];
        quo_q <= {quo_q[VALUE_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

  `RPN_ASSERT_ALWAYS(a_done_not_busy, done_q |-> !busy_q, "divider done while busy")

endmodule

// File: sv/rpn_ctrl.sv
// Controller state machine of the RPN stack calculator.
// Depends on rpn_pkg; drives the datapath through ctrl_cmd_t.
module rpn_ctrl import rpn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_FETCH;
      end
      S_FETCH: state_d = S_EXEC;
      S_EXEC: begin
        state_d = sts_i.div_go ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = accept;
      end
      S_FETCH: cmd_o.rd_en = 1'b1;
      S_EXEC: begin
        cmd_o.div_start = sts_i.div_go;
        cmd_o.commit    = !sts_i.div_go;
      end
      S_DIV: cmd_o.commit = sts_i.div_done;
      S_OUT: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: sv/rpn_dpath.sv
// Datapath of the RPN stack calculator: request, top and count registers,
// entry memory, arithmetic and output register. Depends on rpn_pkg, rpn_div.
`include "rpn_calculator_stack_core_macros.svh"

module rpn_dpath import rpn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_req_t   in_req_i,
  input  ctrl_cmd_t cmd_i,
  output dp_sts_t   sts_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_rsp_t  out_rsp_o
);

  // The top entry lives in top_q; the entries below it live in mem.
  in_req_t            req_q;
  logic [VALUE_W-1:0] top_q, top_d, rd_q, popped_q, popped_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  status_e            status_q, status_d;
  logic [VALUE_W-1:0] mem [STACK_DEPTH];
  logic               out_valid_q;
  out_rsp_t           out_q, rsp;

  logic [CNT_W-1:0]   below_idx, second_idx;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               mem_we;
  logic [VALUE_W-1:0] digit_res, mul_res, op_res, quo;
  logic               div_done, has_two, top_zero, is_div;
  logic               commit_clr, commit_push;

  assign below_idx  = cnt_q - 1'b1;
  assign second_idx = cnt_q - CNT_W'(2);
  assign wr_addr    = below_idx[ADDR_W-1:0];
  assign rd_addr    = second_idx[ADDR_W-1:0];
  assign has_two    = (cnt_q >= CNT_W'(2));
  assign top_zero   = (top_q == '0);
  assign is_div     = (req_q.op_code == OP_DIV);

  // Request register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_req_i;
  end

  // Entry memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_q <= mem[rd_addr];
    if (mem_we) mem[wr_addr] <= top_q;
  end

  // Divider shares the operand registers.
  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Digit entry and operator results.
  assign digit_res = (top_q << 3) + (top_q << 1) + VALUE_W'(req_q.digit);
  assign mul_res   = VALUE_W'(rd_q * top_q);

  always_comb begin
    case (req_q.op_code)
      OP_ADD:  op_res = rd_q + top_q;
      OP_SUB:  op_res = rd_q - top_q;
      OP_MUL:  op_res = mul_res;
      default: op_res = quo;
    endcase
  end

  // Command decode and next stack state.
  always_comb begin
    top_d    = top_q;
    cnt_d    = cnt_q;
    popped_d = '0;
    status_d = STS_OK;
    mem_we   = 1'b0;
    unique case (req_q.cmd)
      CMD_PUSH: begin
        if (cnt_q == CNT_W'(STACK_DEPTH)) begin
          status_d = STS_FULL;
        end else begin
          mem_we = cmd_i.commit && (cnt_q != '0);
          top_d  = VALUE_W'(req_q.push_value);
          cnt_d  = cnt_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (cnt_q == '0) begin
          status_d = STS_UNDERFLOW;
        end else begin
          popped_d = top_q;
          top_d    = rd_q;
          cnt_d    = below_idx;
        end
      end
      CMD_DIGIT: begin
        if (cnt_q == '0) begin
          status_d = STS_UNDERFLOW;
        end else if (top_zero) begin
          top_d = VALUE_W'(req_q.digit);
        end else if (!top_q[VALUE_W-1]) begin
          top_d = digit_res;
        end
      end
      CMD_OPER: begin
        if (!has_two) begin
          status_d = STS_UNDERFLOW;
        end else if (is_div && top_zero) begin
          status_d = STS_DIV_ZERO;
        end else begin
          top_d = op_res;
          cnt_d = below_idx;
        end
      end
      CMD_CLEAR: cnt_d = '0;
      default: ;
    endcase
  end

  // Stack state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      top_q    <= top_d;
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  // Response built from the committed state.
  always_comb begin
    rsp.top_value    = (cnt_q == '0) ? '0 : top_q;
    rsp.popped_value = popped_q;
    rsp.depth        = cnt_q;
    rsp.is_empty     = (cnt_q == '0);
    rsp.status       = status_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= rsp;
  end

  assign out_valid_o    = out_valid_q;
  assign out_rsp_o      = out_q;
  assign sts_o.div_go   = (req_q.cmd == CMD_OPER) && is_div && has_two && !top_zero;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Committed clear and committed push into a stack with room.
  assign commit_clr  = cmd_i.commit && (req_q.cmd == CMD_CLEAR);
  assign commit_push = cmd_i.commit && (req_q.cmd == CMD_PUSH) && (cnt_q != CNT_W'(STACK_DEPTH));

  `RPN_ASSERT(a_clear_empties, commit_clr |=> cnt_q == '0, "clear left entries")
  `RPN_ASSERT(a_push_grows, commit_push |=> cnt_q == $past(cnt_q) + 1'b1, "push did not grow")
  `RPN_ASSERT(a_load_shows, cmd_i.out_load |=> out_valid_q, "loaded response not shown")

endmodule

// File: sv/rpn_calculator_stack_core.sv
// RPN stack calculator: a 16-entry stack of 32-bit values taking push, pop,
// digit entry, operator and clear requests, each answered by one response
// carrying the new top, the popped value, the depth, an empty flag and a
// status code. A request is accepted only while the controller is idle, and
// the next one is taken as soon as the previous response has moved to the
// output register, even if that response is still waiting. Push, pop, digit,
// add, subtract, multiply and clear pass the fetch, execute and output states
// after acceptance; a divide by nonzero also waits in the divide state
// for the bit-serial divider, producing one quotient bit per cycle. The entry
// memory needs no clearing pass. Depends on rpn_pkg, rpn_ctrl and rpn_dpath.
module rpn_calculator_stack_core import rpn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_data_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  // Sequencing of each request.
  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  // Stack storage and arithmetic.
  rpn_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_data_i),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_data_o)
  );

endmodule

// File: verif/tb_rpn_calculator_stack_core.sv
// Testbench for rpn_calculator_stack_core: directed and random request streams
// checked against a cycle-free stack predictor. Depends on rpn_pkg and the core.
module tb_rpn_calculator_stack_core;
  import rpn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 50;
  localparam logic [31:0] MIN_VAL = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL = 32'h7fff_ffff;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_rsp_t out_data_o;

  // Predicted stack contents and fill level.
  logic [31:0]      calc_stack [STACK_DEPTH];
  logic [CNT_W-1:0] calc_count;

  out_rsp_t pending_rsp [$];
  out_rsp_t exp_rsp;
  int       mismatch_count;
  int       cycle_count;
  int       req_count;
  int       burst_left;
  int       stall_mode;
  int       stall_hold;

  rpn_calculator_stack_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Signed division rounding toward zero; the most negative value over
  // minus one wraps back to itself.
  function automatic logic [31:0] trunc_quotient(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] quo;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    quo = mag_n / mag_d;
    return (num[31] ^ den[31]) ? -quo : quo;
  endfunction

  // Applies one request to the predicted stack and returns its response.
  function automatic out_rsp_t apply_command(in_req_t req);
    out_rsp_t    rsp;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
    logic [31:0] popped;
    status_e     sts;
    popped = '0;
    sts = STS_OK;
    case (req.cmd)
      CMD_PUSH: begin
        if (calc_count == STACK_DEPTH) begin
          sts = STS_FULL;
        end else begin
          calc_stack[calc_count] = req.push_value;
          calc_count++;
        end
      end
      CMD_POP: begin
        if (calc_count == 0) begin
          sts = STS_UNDERFLOW;
        end else begin
          calc_count--;
          popped = calc_stack[calc_count];
        end
      end
      CMD_DIGIT: begin
        if (calc_count == 0) begin
          sts = STS_UNDERFLOW;
        end else begin
          lhs = calc_stack[calc_count - 1];
          if (lhs == 0) begin
            calc_stack[calc_count - 1] = {28'd0, req.digit};
          end else if (!lhs[31]) begin
            calc_stack[calc_count - 1] = lhs * 10 + {28'd0, req.digit};
          end
        end
      end
      CMD_OPER: begin
        if (calc_count < 2) begin
          sts = STS_UNDERFLOW;
        end else begin
          rhs = calc_stack[calc_count - 1];
          lhs = calc_stack[calc_count - 2];
          if (req.op_code == OP_DIV && rhs == 0) begin
            sts = STS_DIV_ZERO;
          end else begin
            case (op_e'(req.op_code))
              OP_ADD:  res = lhs + rhs;
              OP_SUB:  res = lhs - rhs;
              OP_MUL:  res = lhs * rhs;
              default: res = trunc_quotient(lhs, rhs);
            endcase
            calc_stack[calc_count - 2] = res;
            calc_count--;
          end
        end
      end
      CMD_CLEAR: calc_count = '0;
      default: ;
    endcase
    rsp.top_value    = (calc_count != 0) ? calc_stack[calc_count - 1] : '0;
    rsp.popped_value = popped;
    rsp.depth        = calc_count;
    rsp.is_empty     = (calc_count == 0);
    rsp.status       = sts;
    return rsp;
  endfunction

  // Mix of ordinary values and the edges of the signed range.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return MIN_VAL;
      2:       return MAX_VAL;
      3:       return '1;
      4:       return $urandom_range(0, 99);
      5:       return -$urandom_range(1, 99);
      default: return $urandom;
    endcase
  endfunction

  // Mostly decimal digits, sometimes the out-of-range codes.
  function automatic logic [3:0] rand_digit();
    return 4'(($urandom_range(0, 4) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9));
  endfunction

  // Sends one request in bursts with random gaps, then records its predicted response.
  task automatic send_req(input logic [2:0] cmd, input logic [31:0] value,
                          input logic [3:0] digit, input logic [1:0] op);
    in_req_t req;
    int      gap;
    req.cmd        = cmd;
    req.push_value = value;
    req.digit      = digit;
    req.op_code    = op;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_rsp.push_back(apply_command(req));
    if (cmd <= CMD_CLEAR) req_count++;
  endtask

  task automatic push_item(input logic [31:0] value);
    send_req(CMD_PUSH, value, 4'd0, OP_ADD);
  endtask

  task automatic oper_item(input op_e op);
    send_req(CMD_OPER, $urandom, rand_digit(), op);
  endtask

  task automatic digit_item(input logic [3:0] digit);
    send_req(CMD_DIGIT, $urandom, digit, 2'($urandom_range(0, 3)));
  endtask

  // Pop, digit entry and operator on an empty stack.
  task automatic test_empty_stack();
    send_req(CMD_POP, $urandom, rand_digit(), 2'($urandom_range(0, 3)));
    digit_item(4'd9);
    oper_item(OP_ADD);
  endtask

  // Undefined command codes must leave the stack as it is.
  task automatic test_unknown_commands();
    for (int c = CMD_CLEAR + 1; c < 8; c++) begin
      send_req(3'(c), $urandom, rand_digit(), 2'($urandom_range(0, 3)));
    end
  endtask

  // Digit entry on a zero, a negative and a positive top, with wrap.
  task automatic test_digit_entry();
    push_item('0);
    digit_item(4'd7);
    digit_item(4'd15);
    push_item('1);
    digit_item(4'd3);
    push_item(MAX_VAL);
    digit_item(4'd9);
  endtask

  // Every operator, divide by zero and the overflowing divide.
  task automatic test_arithmetic();
    push_item(MIN_VAL);
    push_item('1);
    oper_item(OP_DIV);
    push_item('0);
    oper_item(OP_DIV);
    send_req(CMD_POP, '0, 4'd0, OP_ADD);
    push_item(MAX_VAL);
    oper_item(OP_ADD);
    push_item(32'd7);
    oper_item(OP_SUB);
    push_item(-32'sd3);
    oper_item(OP_MUL);
    push_item(-32'sd5);
    oper_item(OP_DIV);
    send_req(CMD_CLEAR, $urandom, rand_digit(), 2'($urandom_range(0, 3)));
  endtask

  // Random expressions, fill and drain runs, clears and raw noise.
  task automatic test_random_sequences();
    int start;
    int n;
    start = req_count;
    while (req_count - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        6: begin
          while (calc_count < STACK_DEPTH) push_item(rand_value());
          repeat ($urandom_range(1, 2)) push_item(rand_value());
          n = $urandom_range(0, STACK_DEPTH + 1);
          repeat (n) begin
            if ($urandom_range(0, 2) == 0) oper_item(op_e'($urandom_range(0, 3)));
            else send_req(CMD_POP, $urandom, rand_digit(), 2'($urandom_range(0, 3)));
          end
        end
        7, 8: begin
          repeat ($urandom_range(1, 3)) begin
            send_req(3'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                     : $urandom_range(0, 4)),
                     $urandom, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
          end
        end
        9: send_req(CMD_CLEAR, $urandom, rand_digit(), 2'($urandom_range(0, 3)));
        default: begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            push_item(rand_value());
            repeat ($urandom_range(0, 3)) digit_item(rand_digit());
          end
          repeat ($urandom_range(1, n + 1)) oper_item(op_e'($urandom_range(0, 3)));
        end
      endcase
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Response checker: each accepted response against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        mismatch_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        compare_field("top_value", exp_rsp.top_value, out_data_o.top_value);
        compare_field("popped_value", exp_rsp.popped_value, out_data_o.popped_value);
        compare_field("depth", 32'(exp_rsp.depth), 32'(out_data_o.depth));
        compare_field("is_empty", 32'(exp_rsp.is_empty), 32'(out_data_o.is_empty));
        compare_field("status", 32'(exp_rsp.status), 32'(out_data_o.status));
      end
    end
  end

  // Receiver backpressure: free, light, heavy or periodic, switching now and then.
  always @(negedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(20, 150);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_hold[2];
    endcase
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    calc_count     = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    req_count      = 0;
    burst_left     = 0;
    stall_mode     = 0;
    stall_hold     = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_stack();
    test_unknown_commands();
    test_digit_entry();
    test_arithmetic();
    test_random_sequences();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: rpn_calculator_stack_core.f
+incdir+sv
sv/rpn_pkg.sv
sv/rpn_div.sv
sv/rpn_ctrl.sv
sv/rpn_dpath.sv
sv/rpn_calculator_stack_core.sv
verif/tb_rpn_calculator_stack_core.sv
